/* rtl/tank_level_depletion_estimator_core_macros.svh */
// Assertion macros for the tank level depletion estimator.
// Used by the controller; expects i_clk and i_rst_n in scope.
`ifndef TANK_LEVEL_DEPLETION_ESTIMATOR_CORE_MACROS_SVH
`define TANK_LEVEL_DEPLETION_ESTIMATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TLDE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlde_pkg.sv */
// Shared types and constants of the tank level depletion estimator.
// No dependencies; the RTL modules refer to it by scoped names.
`default_nettype none
package tlde_pkg;

    typedef struct packed {
        logic               func;
        logic [47:0]        now_ms;
        logic               valid_flag;
        logic               running_flag;
        logic signed [7:0]  level;
        logic [2:0]         fan_mode;
        logic [15:0]        target_setting;
        logic [15:0]        airflow_rate;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  reason_code;
        logic [3:0]  intervals;
        logic [15:0] rate_per_hour;
        logic [31:0] hours_left;
        logic        finite_flag;
    } t_out_res;

    // Reason codes.
    localparam logic [2:0] R_COLLECTING = 3'd0;
    localparam logic [2:0] R_STALE      = 3'd1;
    localparam logic [2:0] R_STOPPED    = 3'd2;
    localparam logic [2:0] R_CHANGED    = 3'd3;
    localparam logic [2:0] R_REFILLED   = 3'd4;
    localparam logic [2:0] R_NO_DROP    = 3'd5;
    localparam logic [2:0] R_ESTIMATE   = 3'd6;

    // Configuration register indexes and reset values.
    localparam logic CFG_STALE_TIMEOUT = 1'b0;
    localparam logic CFG_MIN_WINDOW    = 1'b1;
    localparam logic [31:0] STALE_TIMEOUT_RST = 32'd15000;
    localparam logic [31:0] MIN_WINDOW_RST    = 32'd1800000;

    localparam logic        FUNC_ESTIMATE = 1'b1;
    localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
    localparam logic [6:0]  LEVEL_MAX     = 7'd100;
    localparam logic [6:0]  LEVEL_FLOOR   = 7'd10;
    localparam logic [7:0]  LEVEL_STEP    = 8'd5;
    localparam logic [15:0] AIR_TOL       = 16'd2;
    localparam logic [2:0]  MODE_MAX      = 3'd2;
    localparam logic [2:0]  MEDIAN_LAST   = 3'd4;
    localparam logic [2:0]  MEDIAN_FULL   = 3'd5;

    // Serial divider geometry.
    localparam int          DIV_NUM_W  = 63;
    localparam int          DIV_DEN_W  = 48;
    localparam int          DIV_Q_W    = 32;
    localparam logic [5:0]  RATE_STEPS = 6'd37;
    localparam logic [5:0]  HRS_STEPS  = 6'd63;

    typedef struct packed {
        logic load;
        logic decide;
        logic median;
        logic log_upd;
        logic est_chk;
        logic mul;
        logic rate_go;
        logic rate_wait;
        logic hrs_go;
        logic hrs_wait;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic go_median;
        logic est_go;
        logic chk_collect;
        logic div_done;
        logic rate_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/tank_level_depletion_estimator_core.sv */
// Top level of the tank level depletion estimator: controller plus datapath.
// Depends on tlde_pkg, tlde_ctrl, tlde_dp (and tlde_div below it).
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_req  (tlde_pkg::t_in_req)
//   out      output     o_out_valid / i_out_ready o_out_res (tlde_pkg::t_out_res)
//   cfg      input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// One request is worked on at a time. A feed passes decide and, once the median window
// is full, the median and log states. An estimate ends after decide when it answers at
// once, after the window check when that answers, after the rate division when the rate
// is zero, and else after both divisions on the shared serial divider (37 steps for
// the rate, 63 for the hours). Reset is synchronous, active low.
// A waiting result does not block new requests; only the next estimate result
// waits for the output register to be free.
`default_nettype none
module tank_level_depletion_estimator_core #(
    parameter int LOG_POINTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire tlde_pkg::t_in_req  i_in_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output tlde_pkg::t_out_res      o_out_res,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    tlde_pkg::t_cmd cmd;
    tlde_pkg::t_sts sts;

    tlde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tlde_dp #(
        .LOG_POINTS (LOG_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );
endmodule
`default_nettype wire

/* rtl/tlde_div.sv */
// Restoring serial divider, one quotient bit per cycle, sticky saturation.
// Depends on tlde_pkg for its widths.
`default_nettype none
module tlde_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [5:0]                      i_steps,
    input  wire logic [tlde_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [tlde_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                                 o_done,
    output logic [tlde_pkg::DIV_Q_W-1:0]         o_q,
    output logic                                 o_sat
);
    localparam int NW = tlde_pkg::DIV_NUM_W;
    localparam int DW = tlde_pkg::DIV_DEN_W;
    localparam int QW = tlde_pkg::DIV_Q_W;

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW:0]   r_rem;
    logic [QW-1:0] r_q;
    logic          r_sat;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic          qbit;

    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
        qbit   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= qbit ? rem_sh - {1'b0, r_den} : rem_sh;
            r_q   <= {r_q[QW-2:0], qbit};
            // A bit pushed out of the top means the quotient no longer fits.
            r_sat <= r_sat | r_q[QW-1];
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_sat  = r_sat;
endmodule
`default_nettype wire

/* rtl/tlde_ctrl.sv */
// Sequencing state machine of the depletion estimator.
// Depends on tlde_pkg and the assertion macro header.
`default_nettype none
`include "tank_level_depletion_estimator_core_macros.svh"
module tlde_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire tlde_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output tlde_pkg::t_cmd      o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECIDE    = 12'b0000_0000_0010,
        S_MEDIAN    = 12'b0000_0000_0100,
        S_LOG       = 12'b0000_0000_1000,
        S_EST_CHK   = 12'b0000_0001_0000,
        S_MUL       = 12'b0000_0010_0000,
        S_RATE_GO   = 12'b0000_0100_0000,
        S_RATE_WAIT = 12'b0000_1000_0000,
        S_HRS_GO    = 12'b0001_0000_0000,
        S_HRS_WAIT  = 12'b0010_0000_0000,
        S_EMIT      = 12'b0100_0000_0000,
        S_SPARE     = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.func == tlde_pkg::FUNC_ESTIMATE) begin
                    n_state = i_sts.est_go ? S_EST_CHK : S_EMIT;
                end else begin
                    n_state = i_sts.go_median ? S_MEDIAN : S_IDLE;
                end
            end
            S_MEDIAN: begin
                o_cmd.median = 1'b1;
                n_state = S_LOG;
            end
            S_LOG: begin
                o_cmd.log_upd = 1'b1;
                n_state = S_IDLE;
            end
            S_EST_CHK: begin
                o_cmd.est_chk = 1'b1;
                n_state = i_sts.chk_collect ? S_EMIT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RATE_GO;
            end
            S_RATE_GO: begin
                o_cmd.rate_go = 1'b1;
                n_state = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                o_cmd.rate_wait = 1'b1;
                if (i_sts.div_done) n_state = i_sts.rate_zero ? S_EMIT : S_HRS_GO;
            end
            S_HRS_GO: begin
                o_cmd.hrs_go = 1'b1;
                n_state = S_HRS_WAIT;
            end
            S_HRS_WAIT: begin
                o_cmd.hrs_wait = 1'b1;
                if (i_sts.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_SPARE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `TLDE_ASSERT_IMPL(a_div_done_in_wait, i_sts.div_done,
        (r_state == S_RATE_WAIT || r_state == S_HRS_WAIT), "divider finished outside a wait")
    `TLDE_ASSERT_NEXT(a_accept_decides, (r_state == S_IDLE && i_in_valid),
        (r_state == S_DECIDE), "accepted request not decided next cycle")
    `TLDE_ASSERT_NEXT(a_emit_returns, (r_state == S_EMIT && i_sts.out_free),
        (r_state == S_IDLE), "emitted result did not return to idle")
endmodule
`default_nettype wire

/* rtl/tlde_dp.sv */
// Datapath: session state, median filter, point log memory and estimate maths.
// Depends on tlde_pkg and tlde_div.
`default_nettype none
module tlde_dp #(
    parameter int LOG_POINTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tlde_pkg::t_in_req  i_in_req,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire tlde_pkg::t_cmd     i_cmd,
    input  wire logic               i_out_ready,
    output tlde_pkg::t_sts          o_sts,
    output logic                    o_out_valid,
    output tlde_pkg::t_out_res      o_out_res
);
    localparam int IW = (LOG_POINTS > 2) ? $clog2(LOG_POINTS) : 1;
    localparam int CW = $clog2(LOG_POINTS + 1);

    tlde_pkg::t_in_req  r_in;
    tlde_pkg::t_out_res r_res;
    tlde_pkg::t_out_res r_out;
    logic               r_out_valid;

    logic [31:0] r_stale_to;
    logic [31:0] r_min_win;

    logic [6:0]  r_smp [5];
    logic [2:0]  r_wpos;
    logic [2:0]  r_fill;
    logic        r_active;
    logic [1:0]  r_held_mode;
    logic [15:0] r_held_tgt;
    logic [15:0] r_held_air;
    logic [47:0] r_last_t;
    logic [6:0]  r_lm;
    logic [6:0]  r_newest;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_head;
    logic [2:0]  r_last_reason;
    logic [6:0]  r_med;

    logic [47:0] r_pt_t [LOG_POINTS];
    logic [6:0]  r_pt_l [LOG_POINTS];
    logic [47:0] r_rd_t;
    logic [6:0]  r_rd_l;

    logic [6:0]  r_drop;
    logic [47:0] r_span;
    logic [28:0] r_denom;
    logic [54:0] r_hnum;

    // Decode of the held request.
    logic        bad, stop, gap, changed, restart;
    logic [2:0]  why;
    logic [15:0] air_d;
    logic [2:0]  wpos_eff, fill_eff;
    logic [8:0]  cnt_m1;
    logic        est_go;
    logic [3:0]  ints;

    always_comb begin
        bad  = !r_in.valid_flag || r_in.level < 0 ||
               r_in.level > $signed({1'b0, tlde_pkg::LEVEL_MAX});
        stop = !r_in.running_flag || r_in.fan_mode > tlde_pkg::MODE_MAX ||
               r_in.level <= $signed({1'b0, tlde_pkg::LEVEL_FLOOR});
        gap  = (r_in.now_ms > r_last_t) && ((r_in.now_ms - r_last_t) > {16'd0, r_stale_to});
        air_d = (r_in.airflow_rate > r_held_air) ? r_in.airflow_rate - r_held_air
                                                 : r_held_air - r_in.airflow_rate;
        changed = (r_in.fan_mode[1:0] != r_held_mode) || (r_in.target_setting != r_held_tgt) ||
                  (r_in.fan_mode == 3'd0 && air_d > tlde_pkg::AIR_TOL);
        restart = r_active && (gap || changed);
        why = !r_active ? tlde_pkg::R_COLLECTING :
              gap       ? tlde_pkg::R_STALE : tlde_pkg::R_CHANGED;
        wpos_eff = restart ? 3'd0 : r_wpos;
        fill_eff = restart ? 3'd0 : r_fill;
        cnt_m1 = 9'(r_cnt) - 9'd1;
        est_go = r_active && !gap && (9'(r_cnt) >= 9'd2);
        ints   = (cnt_m1 > 9'd15) ? 4'hF : cnt_m1[3:0];
    end

    // Median of five by rank: each sample counts those ordered below it.
    logic [2:0] v_rank [5];
    logic [6:0] med_sel;
    always_comb begin
        med_sel = '0;
        for (int i = 0; i < 5; i++) begin
            v_rank[i] = '0;
            for (int j = 0; j < 5; j++) begin
                if (j != i && (r_smp[j] < r_smp[i] || (r_smp[j] == r_smp[i] && j < i)))
                    v_rank[i] = v_rank[i] + 3'd1;
            end
            if (v_rank[i] == 3'd2) med_sel = r_smp[i];
        end
    end

    // Log update.
    logic          refill, take, full;
    logic [CW-1:0] cnt_eff, cnt_base;
    logic [IW:0]   h1, head_sum;
    logic [IW-1:0] head_nx, wr_idx;
    always_comb begin
        refill   = (r_cnt != '0) && ({1'b0, r_med} >= {1'b0, r_lm} + tlde_pkg::LEVEL_STEP);
        cnt_eff  = refill ? '0 : r_cnt;
        take     = (cnt_eff == '0) ||
                   ({1'b0, r_med} + tlde_pkg::LEVEL_STEP <= {1'b0, r_newest});
        full     = (cnt_eff == CW'(LOG_POINTS));
        h1       = {1'b0, r_head} + (IW+1)'(1);
        head_nx  = !full ? r_head :
                   (h1 >= (IW+1)'(LOG_POINTS)) ? IW'(h1 - (IW+1)'(LOG_POINTS)) : h1[IW-1:0];
        cnt_base = full ? CW'(LOG_POINTS - 1) : cnt_eff;
        head_sum = {1'b0, head_nx} + (IW+1)'(cnt_base);
        wr_idx   = (head_sum >= (IW+1)'(LOG_POINTS)) ?
                   IW'(head_sum - (IW+1)'(LOG_POINTS)) : head_sum[IW-1:0];
    end

    // Estimate window checks on the oldest point.
    logic [6:0]  drop;
    logic [47:0] span;
    logic        collect;
    logic [6:0]  lm10;
    always_comb begin
        drop    = (r_rd_l > r_lm) ? r_rd_l - r_lm : 7'd0;
        span    = r_in.now_ms - r_rd_t;
        collect = (drop < tlde_pkg::LEVEL_FLOOR) || (r_in.now_ms <= r_rd_t) ||
                  (span < {16'd0, r_min_win});
        lm10    = (r_lm > tlde_pkg::LEVEL_FLOOR) ? r_lm - tlde_pkg::LEVEL_FLOOR : 7'd0;
    end

    // Shared divider.
    logic                           div_start, div_done, div_sat;
    logic [5:0]                     div_steps;
    logic [tlde_pkg::DIV_NUM_W-1:0] div_num;
    logic [tlde_pkg::DIV_DEN_W-1:0] div_den;
    logic [tlde_pkg::DIV_Q_W-1:0]   div_q;
    logic                           rate_zero;
    always_comb begin
        div_start = i_cmd.rate_go | i_cmd.hrs_go;
        div_steps = i_cmd.rate_go ? tlde_pkg::RATE_STEPS : tlde_pkg::HRS_STEPS;
        div_num   = i_cmd.rate_go ? {r_denom, 34'd0} : {r_hnum, 8'd0};
        div_den   = i_cmd.rate_go ? r_span : {19'd0, r_denom};
        rate_zero = (div_q == '0) && !div_sat;
    end

    tlde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_steps (div_steps),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_sat   (div_sat)
    );

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale_to <= tlde_pkg::STALE_TIMEOUT_RST;
            r_min_win  <= tlde_pkg::MIN_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlde_pkg::CFG_STALE_TIMEOUT: r_stale_to <= i_cfg_data;
                tlde_pkg::CFG_MIN_WINDOW:    r_min_win  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Session control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_held_mode   <= '0;
            r_held_tgt    <= '0;
            r_held_air    <= '0;
            r_last_t      <= '0;
            r_lm          <= '0;
            r_cnt         <= '0;
            r_head        <= '0;
            r_wpos        <= '0;
            r_fill        <= '0;
            r_last_reason <= tlde_pkg::R_COLLECTING;
        end else if (i_cmd.decide && r_in.func != tlde_pkg::FUNC_ESTIMATE) begin
            if (bad || stop) begin
                r_active      <= 1'b0;
                r_held_mode   <= '0;
                r_held_tgt    <= '0;
                r_held_air    <= '0;
                r_last_t      <= '0;
                r_lm          <= '0;
                r_cnt         <= '0;
                r_head        <= '0;
                r_wpos        <= '0;
                r_fill        <= '0;
                r_last_reason <= bad ? tlde_pkg::R_STALE : tlde_pkg::R_STOPPED;
            end else begin
                if (!r_active || restart) begin
                    r_active      <= 1'b1;
                    r_held_mode   <= r_in.fan_mode[1:0];
                    r_held_tgt    <= r_in.target_setting;
                    r_held_air    <= r_in.airflow_rate;
                    r_last_reason <= why;
                end
                if (restart) begin
                    r_lm   <= '0;
                    r_cnt  <= '0;
                    r_head <= '0;
                end
                r_last_t <= r_in.now_ms;
                r_wpos   <= (wpos_eff == tlde_pkg::MEDIAN_LAST) ? 3'd0 : wpos_eff + 3'd1;
                r_fill   <= (fill_eff == tlde_pkg::MEDIAN_FULL) ? fill_eff : fill_eff + 3'd1;
            end
        end else if (i_cmd.log_upd) begin
            if (refill) r_last_reason <= tlde_pkg::R_REFILLED;
            r_lm <= r_med;
            if (take) begin
                r_head <= head_nx;
                r_cnt  <= cnt_base + CW'(1);
            end else begin
                r_cnt <= cnt_eff;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_req;
        if (i_cmd.decide && r_in.func != tlde_pkg::FUNC_ESTIMATE && !bad && !stop)
            r_smp[wpos_eff] <= r_in.level[6:0];
        if (i_cmd.median) r_med <= med_sel;
        if (i_cmd.log_upd && take) r_newest <= r_med;
        if (i_cmd.est_chk) begin
            r_drop <= drop;
            r_span <= span;
        end
        if (i_cmd.mul) begin
            r_denom <= {22'd0, r_drop} * {7'd0, tlde_pkg::MS_PER_HOUR};
            r_hnum  <= {48'd0, lm10} * {7'd0, r_span};
        end
        if (i_cmd.decide) begin
            r_res.reason_code   <= (r_active && gap) ? tlde_pkg::R_STALE : r_last_reason;
            r_res.intervals     <= est_go ? ints : 4'd0;
            r_res.rate_per_hour <= '0;
            r_res.hours_left    <= '0;
            r_res.finite_flag   <= 1'b0;
        end
        if (i_cmd.est_chk && collect) r_res.reason_code <= tlde_pkg::R_COLLECTING;
        if (i_cmd.rate_wait && div_done) begin
            if (rate_zero) begin
                r_res.reason_code <= tlde_pkg::R_NO_DROP;
            end else begin
                r_res.rate_per_hour <= (div_sat || div_q[31:16] != '0) ? 16'hFFFF
                                                                       : div_q[15:0];
            end
        end
        if (i_cmd.hrs_wait && div_done) begin
            r_res.hours_left  <= div_sat ? 32'hFFFF_FFFF : div_q;
            r_res.reason_code <= tlde_pkg::R_ESTIMATE;
            r_res.finite_flag <= 1'b1;
        end
    end

    // Point log memory; the oldest point is read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.log_upd && take) begin
            r_pt_t[wr_idx] <= r_in.now_ms;
            r_pt_l[wr_idx] <= r_med;
        end
        r_rd_t <= r_pt_t[r_head];
        r_rd_l <= r_pt_l[r_head];
    end

    // Output register.
    logic out_free;
    assign out_free = !r_out_valid || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && out_free) r_out <= r_res;
    end

    always_comb begin
        o_sts.func        = r_in.func;
        o_sts.go_median   = !bad && !stop && (fill_eff >= tlde_pkg::MEDIAN_LAST);
        o_sts.est_go      = est_go;
        o_sts.chk_collect = collect;
        o_sts.div_done    = div_done;
        o_sts.rate_zero   = rate_zero;
        o_sts.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;
endmodule
`default_nettype wire

/* verif/tb_tank_level_depletion_estimator_core.sv */
// Self-checking testbench for the tank level depletion estimator core.
// Depends on tlde_pkg and tank_level_depletion_estimator_core; predicts every
// estimate result in step with accepted requests and compares field by field.
`timescale 1ns / 1ps
module tb_tank_level_depletion_estimator_core;

    localparam int NPTS = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    tlde_pkg::t_in_req   i_in_req;
    logic                o_out_valid;
    logic                i_out_ready;
    tlde_pkg::t_out_res  o_out_res;
    logic                i_cfg_we;
    logic                i_cfg_idx;
    logic [31:0]         i_cfg_data;

    tank_level_depletion_estimator_core #(.LOG_POINTS(NPTS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_req(i_in_req),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_res(o_out_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Predictor state.
    logic [31:0] stale_lim;
    logic [31:0] window_lim;
    logic [6:0]  win [5];
    int          win_pos, win_fill;
    logic        active;
    logic [2:0]  h_mode;
    logic [15:0] h_target, h_air;
    logic [47:0] last_t;
    logic [6:0]  last_med;
    int          npts, head;
    logic [47:0] pt_t [NPTS];
    logic [6:0]  pt_l [NPTS];
    logic [2:0]  reason;

    tlde_pkg::t_out_res expected_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          sent = 0;
    logic        quiet = 1'b0;
    logic [47:0] clock_ms = 48'd0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("tb_tank_level_depletion_estimator_core: FAIL");
        $finish;
    end

    task automatic clear_tank(input logic [2:0] why);
        for (int i = 0; i < 5; i++) win[i] = '0;
        win_pos = 0; win_fill = 0; active = 1'b0;
        h_mode = '0; h_target = '0; h_air = '0; last_t = '0; last_med = '0;
        npts = 0; head = 0; reason = why;
    endtask

    function automatic logic is_stale(input logic [47:0] t);
        return t > last_t && (t - last_t) > {16'd0, stale_lim};
    endfunction

    function automatic logic [6:0] median5();
        logic [6:0] s [5];
        logic [6:0] x;
        for (int i = 0; i < 5; i++) s[i] = win[i];
        for (int i = 1; i < 5; i++)
            for (int j = i; j > 0; j--)
                if (s[j] < s[j-1]) begin
                    x = s[j]; s[j] = s[j-1]; s[j-1] = x;
                end
        return s[2];
    endfunction

    task automatic track_feed(input tlde_pkg::t_in_req r);
        logic [2:0]  why;
        logic [15:0] d;
        logic [6:0]  m;
        int          slot;
        why = tlde_pkg::R_COLLECTING;
        if (!r.valid_flag || r.level < 0 || r.level > 100) begin
            clear_tank(tlde_pkg::R_STALE);
            return;
        end
        if (!r.running_flag || r.fan_mode > tlde_pkg::MODE_MAX || r.level <= 10) begin
            clear_tank(tlde_pkg::R_STOPPED);
            return;
        end
        if (active) begin
            d = r.airflow_rate > h_air ? r.airflow_rate - h_air : h_air - r.airflow_rate;
            if (is_stale(r.now_ms)) begin
                clear_tank(tlde_pkg::R_STALE); why = tlde_pkg::R_STALE;
            end else if (r.fan_mode != h_mode || r.target_setting != h_target ||
                         (r.fan_mode == 0 && d > 2)) begin
                clear_tank(tlde_pkg::R_CHANGED); why = tlde_pkg::R_CHANGED;
            end
        end
        if (!active) begin
            active = 1'b1; h_mode = r.fan_mode; h_target = r.target_setting;
            h_air = r.airflow_rate; reason = why;
        end
        last_t = r.now_ms;
        win[win_pos] = r.level[6:0];
        win_pos = (win_pos + 1) % 5;
        if (win_fill < 5) win_fill++;
        if (win_fill < 5) return;
        m = median5();
        if (npts != 0 && {1'b0, m} >= {1'b0, last_med} + 8'd5) begin
            npts = 0; reason = tlde_pkg::R_REFILLED;
        end
        last_med = m;
        if (npts == 0 || {1'b0, m} + 8'd5 <= {1'b0, pt_l[(head + npts - 1) % NPTS]}) begin
            if (npts >= NPTS) begin
                head = (head + 1) % NPTS; npts = NPTS - 1;
            end
            slot = (head + npts) % NPTS;
            pt_t[slot] = r.now_ms;
            pt_l[slot] = m;
            npts++;
        end
    endtask

    function automatic tlde_pkg::t_out_res predict_estimate(input logic [47:0] t);
        tlde_pkg::t_out_res o;
        logic [47:0] t0, span;
        logic [6:0]  l0;
        int unsigned drop;
        logic [127:0] den, rate, hrs;
        o = '0;
        o.reason_code = reason;
        if (!active) return o;
        if (is_stale(t)) begin
            o.reason_code = tlde_pkg::R_STALE;
            return o;
        end
        if (npts < 2) return o;
        o.intervals = (npts - 1) > 15 ? 4'd15 : 4'(npts - 1);
        t0 = pt_t[head]; l0 = pt_l[head];
        drop = l0 > last_med ? l0 - last_med : 0;
        if (drop < 10 || t <= t0) begin
            o.reason_code = tlde_pkg::R_COLLECTING;
            return o;
        end
        span = t - t0;
        if (span < {16'd0, window_lim}) begin
            o.reason_code = tlde_pkg::R_COLLECTING;
            return o;
        end
        den = 128'(drop) * 128'd3600000;
        rate = (den * 256) / span;
        if (rate == 0) begin
            o.reason_code = tlde_pkg::R_NO_DROP;
            return o;
        end
        if (rate > 128'hFFFF) rate = 128'hFFFF;
        hrs = (128'(last_med > 10 ? last_med - 10 : 0) * span * 256) / den;
        if (hrs > 128'hFFFF_FFFF) hrs = 128'hFFFF_FFFF;
        o.reason_code = tlde_pkg::R_ESTIMATE;
        o.rate_per_hour = rate[15:0];
        o.hours_left = hrs[31:0];
        o.finite_flag = 1'b1;
        return o;
    endfunction

    // Sends one request; the prediction is taken when it is accepted.
    task automatic send_request(input tlde_pkg::t_in_req r);
        if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 11)) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_req = r;
        do @(posedge i_clk); while (!o_in_ready);
        if (r.func == tlde_pkg::FUNC_ESTIMATE) expected_q.push_back(predict_estimate(r.now_ms));
        else track_feed(r);
        sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Output side: random stall bursts, then check each accepted result.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %p", $time, o_out_res);
            end else begin
                tlde_pkg::t_out_res e;
                e = expected_q.pop_front();
                if (e.reason_code !== o_out_res.reason_code ||
                    e.intervals !== o_out_res.intervals ||
                    e.rate_per_hour !== o_out_res.rate_per_hour ||
                    e.hours_left !== o_out_res.hours_left ||
                    e.finite_flag !== o_out_res.finite_flag) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, e, o_out_res);
                end
            end
        end
    end

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == tlde_pkg::CFG_STALE_TIMEOUT) stale_lim = v; else window_lim = v;
    endtask

    function automatic tlde_pkg::t_in_req make_feed(input logic [47:0] t,
                                                    input logic signed [7:0] lv,
                                                    input logic [2:0] md,
                                                    input logic [15:0] tg,
                                                    input logic [15:0] af);
        tlde_pkg::t_in_req r;
        r.func = 1'b0; r.now_ms = t; r.valid_flag = 1'b1; r.running_flag = 1'b1;
        r.level = lv; r.fan_mode = md; r.target_setting = tg; r.airflow_rate = af;
        return r;
    endfunction

    function automatic tlde_pkg::t_in_req make_estimate(input logic [47:0] t);
        tlde_pkg::t_in_req r;
        r = '0;
        r.func = tlde_pkg::FUNC_ESTIMATE; r.now_ms = t;
        return r;
    endfunction

    // Directed: bad levels, stop, changes, a stale gap, and estimates before any points are logged.
    task automatic test_directed();
        tlde_pkg::t_in_req r;
        send_request(make_estimate(48'd0));
        r = make_feed(48'd10, 8'sd50, 3'd1, 16'd5, 16'd7);
        r.valid_flag = 1'b0;                         send_request(r);
        send_request(make_estimate(48'd11));
        send_request(make_feed(48'd12, -8'sd128, 3'd1, 16'd5, 16'd7));
        send_request(make_feed(48'd13, 8'sd101, 3'd1, 16'd5, 16'd7));
        send_request(make_feed(48'd14, 8'sd127, 3'd1, 16'd5, 16'd7));
        send_request(make_feed(48'd15, 8'sd10, 3'd1, 16'd5, 16'd7));
        send_request(make_estimate(48'd16));
        send_request(make_feed(48'd17, 8'sd50, 3'd7, 16'd5, 16'd7));
        r = make_feed(48'd18, 8'sd50, 3'd1, 16'd5, 16'd7);
        r.running_flag = 1'b0;                       send_request(r);
        send_request(make_feed(48'd20, 8'sd100, 3'd0, 16'hFFFF, 16'hFFFF));
        send_request(make_feed(48'd21, 8'sd100, 3'd0, 16'hFFFF, 16'hFFFC));
        send_request(make_estimate(48'd22));
        send_request(make_feed(48'd23, 8'sd100, 3'd2, 16'h0000, 16'h0000));
        send_request(make_feed(48'h7FFF_FFFF_FFFF, 8'sd90, 3'd2, 16'h0, 16'h0));
        send_request(make_estimate(48'hFFFF_FFFF_FFFF));
        clock_ms = 48'd1000;
    endtask

    // Random sessions: mostly steady draining runs with occasional disturbances.
    task automatic test_random(input int n_items, input int mode_bias);
        int lv, md;
        logic [15:0] tg, af;
        tlde_pkg::t_in_req r;
        lv = 100; md = $urandom_range(0, 2); tg = 16'($urandom); af = 16'($urandom);
        for (int k = 0; k < n_items; k++) begin
            int pick;
            pick = $urandom_range(0, 99);
            clock_ms += (pick < 3) ? 48'($urandom_range(0, 40000)) : 48'($urandom_range(0, mode_bias));
            if (pick < 20) send_request(make_estimate(clock_ms));
            else if (pick < 25) begin
                r = '0;
                r.now_ms = clock_ms - 48'($urandom_range(0, 20));
                r.valid_flag = 1'($urandom); r.running_flag = 1'($urandom);
                r.level = 8'($urandom); r.fan_mode = 3'($urandom);
                r.target_setting = 16'($urandom); r.airflow_rate = 16'($urandom);
                send_request(r);
                if (pick == 24) begin
                    lv = 100; md = $urandom_range(0, 2); tg = 16'($urandom); af = 16'($urandom);
                end
            end else begin
                if (pick < 27) lv = 100;
                else if ($urandom_range(0, 2) == 0 && lv > 12) lv -= $urandom_range(0, 3);
                if (lv < 20) lv = 100;
                if (pick == 27) af = af + 16'($urandom_range(0, 4));
                send_request(make_feed(clock_ms, 8'(lv + $urandom_range(0, 2)), 3'(md),
                                       tg, af));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_req = '0;
        i_cfg_we = 1'b0; i_cfg_idx = tlde_pkg::CFG_STALE_TIMEOUT; i_cfg_data = '0;
        stale_lim = tlde_pkg::STALE_TIMEOUT_RST; window_lim = tlde_pkg::MIN_WINDOW_RST;
        clear_tank(tlde_pkg::R_COLLECTING);
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(400, 14000);
        drain();
        write_reg(tlde_pkg::CFG_STALE_TIMEOUT, 32'd20000);
        write_reg(tlde_pkg::CFG_MIN_WINDOW, 32'd1);
        test_random(400, 9000);
        drain();
        write_reg(tlde_pkg::CFG_STALE_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(tlde_pkg::CFG_MIN_WINDOW, 32'd60000);
        test_random(350, 60000);
        drain();
        write_reg(tlde_pkg::CFG_STALE_TIMEOUT, 32'd1);
        write_reg(tlde_pkg::CFG_MIN_WINDOW, 32'hFFFF_FFFF);
        test_random(100, 2);
        drain();
        write_reg(tlde_pkg::CFG_STALE_TIMEOUT, 32'd30000);
        write_reg(tlde_pkg::CFG_MIN_WINDOW, 32'd100000);
        quiet = 1'b1;
        test_random(200, 25000);
        drain();
        $display("Sent %0d requests with five register settings; checked %0d estimates.",
                 sent, results_seen);
        if (errors == 0) $display("tb_tank_level_depletion_estimator_core: PASS");
        else $display("tb_tank_level_depletion_estimator_core: FAIL");
        $finish;
    end
endmodule
